// ===== src/pre_pkg.sv =====
// Shared constants, codes and the LFSR step for the page replacement engine.
package pre_pkg;

  localparam int DEF_MAX_FRAMES = 64;
  localparam int DEF_STAMP_BITS = 32;

  localparam int PAGE_W     = 24;
  localparam int IDX_OUT_W  = 6;
  localparam int CNT_W      = 32;
  localparam int FC_W       = 7;
  localparam int SH_W       = 5;
  localparam int POL_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [FC_W-1:0] FC_RESET = 7'd64;
  localparam logic [SH_W-1:0] SH_RESET = 5'd12;
  localparam logic [SH_W-1:0] SH_MIN   = 5'd8;
  localparam logic [SH_W-1:0] SH_MAX   = 5'd20;

  localparam int                LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_POLY = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  typedef enum logic [POL_W-1:0] {
    POL_FIFO   = 2'd0,
    POL_LRU    = 2'd1,
    POL_RANDOM = 2'd2,
    POL_CLOCK  = 2'd3
  } policy_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COUNT = 2'd0,
    CFG_PAGE_OFFSET = 2'd1,
    CFG_POLICY      = 2'd2
  } cfg_idx_t;

  // Galois step: shift right, fold in the polynomial when a one falls out.
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] sh;
    sh = s >> 1;
    return s[0] ? (sh ^ LFSR_POLY) : sh;
  endfunction

endpackage

// ===== src/page_replacement_engine.sv =====
// Page replacement engine: frame table lookup, fill and victim selection.
//
//  channel   dir  handshake                     payload
//  access    in   access_valid / access_stall   address, is_write
//  result    out  result_valid / result_stall   hit, evicted, writeback, victim_page,
//                                               frame_index, hit_total, miss_total,
//                                               writeback_total
//  config    in   write_enable                  reg_index, write_data
//
// One frame table read per cycle. A hit ends the scan at the matching frame; a miss
// scans the used frames, then fills a free frame or evicts: fifo/lru take the frame
// with the oldest stamp; random takes the LFSR value modulo the frame count from the
// remainder unit; second chance sweeps from the hand, clearing reference bits.
// Synchronous reset clears control state; the frame table needs no clearing.
// access_stall is high until the result is loaded; one result may wait while stalled.
module page_replacement_engine #(
  parameter int MAX_FRAMES = pre_pkg::DEF_MAX_FRAMES,
  parameter int STAMP_BITS = pre_pkg::DEF_STAMP_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            write_enable,
  input  logic [pre_pkg::CFG_IDX_W-1:0]   reg_index,
  input  logic [pre_pkg::CFG_DATA_W-1:0]  write_data,
  input  logic                            access_valid,
  output logic                            access_stall,
  input  logic [31:0]                     address,
  input  logic                            is_write,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            hit,
  output logic                            evicted,
  output logic                            writeback,
  output logic [pre_pkg::PAGE_W-1:0]      victim_page,
  output logic [pre_pkg::IDX_OUT_W-1:0]   frame_index,
  output logic [pre_pkg::CNT_W-1:0]       hit_total,
  output logic [pre_pkg::CNT_W-1:0]       miss_total,
  output logic [pre_pkg::CNT_W-1:0]       writeback_total
);

  localparam int NW = $clog2(MAX_FRAMES + 1);
  localparam int HW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int PW = pre_pkg::PAGE_W;
  localparam int CW = pre_pkg::CNT_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_MODW   = 7'b0000100,
    S_CLOCK  = 7'b0001000,
    S_VREAD  = 7'b0010000,
    S_VWRITE = 7'b0100000,
    S_POST   = 7'b1000000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [pre_pkg::FC_W-1:0] frame_count;
  logic [pre_pkg::SH_W-1:0] page_offset_bits;
  pre_pkg::policy_t         policy;

  // persistent state
  logic [NW-1:0]             fill;
  logic [STAMP_BITS-1:0]     stamp_clock;
  logic [HW-1:0]             hand;
  logic [pre_pkg::LFSR_W-1:0] lfsr;
  logic [CW-1:0]             hit_count, miss_count, wb_count;

  // frame table
  logic [PW-1:0]         page_mem  [MAX_FRAMES];
  logic                  dirty_mem [MAX_FRAMES];
  logic [STAMP_BITS-1:0] stamp_mem [MAX_FRAMES];
  logic                  ref_mem   [MAX_FRAMES];
  logic [PW-1:0]         rd_page;
  logic                  rd_dirty;
  logic [STAMP_BITS-1:0] rd_stamp;
  logic                  rd_ref;
  logic [HW-1:0]         rd_addr;
  logic                  mem_we;
  logic [HW-1:0]         mem_wa;
  logic [PW-1:0]         mem_wpage;
  logic                  mem_wdirty;
  logic [STAMP_BITS-1:0] mem_wstamp;
  logic                  mem_wref;

  // per-access working registers
  logic [PW-1:0]         page;
  logic                  wr;
  logic [NW-1:0]         n_lat;
  logic [NW-1:0]         scan_lim;
  logic [HW-1:0]         iss_idx;
  logic [NW-1:0]         iss_cnt;
  logic                  pipe_v;
  logic [HW-1:0]         pipe_idx;
  logic                  pipe_last;
  logic [HW-1:0]         best_idx;
  logic [STAMP_BITS-1:0] best_stamp;
  logic [HW-1:0]         f;
  logic [HW-1:0]         clk_start;
  logic                  is_hit, is_evict, is_wb;
  logic [PW-1:0]         victim;

  // combinational
  logic [pre_pkg::SH_W-1:0]   sh_c;
  logic [NW-1:0]              n_acc, used_acc;
  logic [PW-1:0]              page_acc;
  logic [pre_pkg::LFSR_W-1:0] lfsr_nxt;
  logic                       accept, iss_go, out_free;
  logic [HW-1:0]              iss_idx_nx;
  logic                       scan_hit, scan_end, take_best, restamp;
  logic [HW-1:0]              choice, hand_nx;
  logic                       stamp_adv, fill_inc, lfsr_adv, mod_start, mod_done;
  logic [pre_pkg::LFSR_W-1:0] mod_dvd;
  logic [NW-1:0]              mod_rem;

  assign accept       = (state == S_IDLE) && access_valid;
  assign access_stall = (state != S_IDLE);
  assign out_free     = !result_valid || !result_stall;

  always_comb begin
    if (page_offset_bits < pre_pkg::SH_MIN)      sh_c = pre_pkg::SH_MIN;
    else if (page_offset_bits > pre_pkg::SH_MAX) sh_c = pre_pkg::SH_MAX;
    else                                         sh_c = page_offset_bits;
    if (frame_count == '0)                       n_acc = NW'(1);
    else if (int'(frame_count) > MAX_FRAMES)     n_acc = NW'(MAX_FRAMES);
    else                                         n_acc = NW'(frame_count);
  end

  assign page_acc = PW'(address >> sh_c);
  assign used_acc = (fill < n_acc) ? fill : n_acc;
  assign lfsr_nxt = pre_pkg::lfsr_step(lfsr);

  assign iss_go     = ((state == S_SCAN) || (state == S_CLOCK)) && (iss_cnt < scan_lim);
  assign iss_idx_nx = (NW'(iss_idx) + NW'(1) == n_lat) ? '0 : iss_idx + HW'(1);
  assign rd_addr    = (state == S_VREAD) ? f : iss_idx;

  assign scan_hit  = (state == S_SCAN) && pipe_v && (rd_page == page);
  assign scan_end  = (state == S_SCAN) && !scan_hit &&
                     ((scan_lim == '0) || (pipe_v && pipe_last));
  assign take_best = (pipe_idx == '0) || (rd_stamp < best_stamp);
  assign restamp   = (policy == pre_pkg::POL_LRU) || (policy == pre_pkg::POL_RANDOM);

  // second chance: all frames passed over means the hand frame is taken
  assign choice  = rd_ref ? clk_start : pipe_idx;
  assign hand_nx = (NW'(choice) + NW'(1) == n_lat) ? '0 : choice + HW'(1);

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_wa     = f;
    mem_wpage  = page;
    mem_wdirty = wr;
    mem_wstamp = stamp_clock;
    mem_wref   = 1'b0;
    stamp_adv  = 1'b0;
    fill_inc   = 1'b0;
    lfsr_adv   = 1'b0;
    mod_start  = 1'b0;
    mod_dvd    = lfsr_nxt;
    case (state)
      S_IDLE: begin
        if (access_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_hit) begin
          mem_we     = 1'b1;
          mem_wa     = pipe_idx;
          mem_wdirty = rd_dirty | wr;
          mem_wstamp = restamp ? stamp_clock : rd_stamp;
          mem_wref   = (policy == pre_pkg::POL_CLOCK) ? 1'b1 : rd_ref;
          stamp_adv  = restamp;
          state_next = S_POST;
        end else if (scan_end) begin
          if (fill < n_lat) begin
            mem_we     = 1'b1;
            mem_wa     = HW'(fill);
            stamp_adv  = 1'b1;
            fill_inc   = 1'b1;
            state_next = S_POST;
          end else begin
            case (policy)
              pre_pkg::POL_RANDOM: begin
                lfsr_adv   = 1'b1;
                mod_start  = 1'b1;
                state_next = S_MODW;
              end
              pre_pkg::POL_CLOCK: begin
                mod_start  = 1'b1;
                mod_dvd    = pre_pkg::LFSR_W'(hand);
                state_next = S_MODW;
              end
              default: state_next = S_VREAD;
            endcase
          end
        end
      end
      S_MODW: begin
        if (mod_done) state_next = (policy == pre_pkg::POL_CLOCK) ? S_CLOCK : S_VREAD;
      end
      S_CLOCK: begin
        if (pipe_v) begin
          if (rd_ref) begin
            // pass over: clear the reference bit, keep the rest
            mem_we     = 1'b1;
            mem_wa     = pipe_idx;
            mem_wpage  = rd_page;
            mem_wdirty = rd_dirty;
            mem_wstamp = rd_stamp;
            if (pipe_last) state_next = S_VREAD;
          end else begin
            state_next = S_VREAD;
          end
        end
      end
      S_VREAD: state_next = S_VWRITE;
      S_VWRITE: begin
        mem_we     = 1'b1;
        stamp_adv  = 1'b1;
        state_next = S_POST;
      end
      S_POST: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  pre_modu #(
    .NW(NW)
  ) u_modu (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (mod_dvd),
    .divisor   (n_lat),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // frame table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_mem[mem_wa]  <= mem_wpage;
      dirty_mem[mem_wa] <= mem_wdirty;
      stamp_mem[mem_wa] <= mem_wstamp;
      ref_mem[mem_wa]   <= mem_wref;
    end
    rd_page  <= page_mem[rd_addr];
    rd_dirty <= dirty_mem[rd_addr];
    rd_stamp <= stamp_mem[rd_addr];
    rd_ref   <= ref_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      frame_count      <= pre_pkg::FC_RESET;
      page_offset_bits <= pre_pkg::SH_RESET;
      policy           <= pre_pkg::POL_FIFO;
      fill             <= '0;
      stamp_clock      <= '0;
      hand             <= '0;
      lfsr             <= pre_pkg::LFSR_SEED;
      hit_count        <= '0;
      miss_count       <= '0;
      wb_count         <= '0;
      result_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (write_enable) begin
        case (pre_pkg::cfg_idx_t'(reg_index))
          pre_pkg::CFG_FRAME_COUNT: frame_count      <= write_data;
          pre_pkg::CFG_PAGE_OFFSET: page_offset_bits <= write_data[pre_pkg::SH_W-1:0];
          pre_pkg::CFG_POLICY:
            policy <= pre_pkg::policy_t'(write_data[pre_pkg::POL_W-1:0]);
          default: ;
        endcase
      end
      if (fill_inc)  fill        <= fill + NW'(1);
      if (stamp_adv) stamp_clock <= stamp_clock + STAMP_BITS'(1);
      if (lfsr_adv)  lfsr        <= lfsr_nxt;
      if ((state == S_CLOCK) && (state_next == S_VREAD)) hand <= hand_nx;
      if ((state == S_POST) && out_free) begin
        result_valid <= 1'b1;
        hit_count    <= hit_count + CW'(is_hit);
        miss_count   <= miss_count + CW'(!is_hit);
        wb_count     <= wb_count + CW'(is_wb);
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    pipe_v    <= iss_go;
    pipe_idx  <= iss_idx;
    pipe_last <= (iss_cnt == scan_lim - NW'(1));
    if (iss_go) begin
      iss_idx <= iss_idx_nx;
      iss_cnt <= iss_cnt + NW'(1);
    end
    if (accept) begin
      page     <= page_acc;
      wr       <= is_write;
      n_lat    <= n_acc;
      scan_lim <= used_acc;
      iss_idx  <= '0;
      iss_cnt  <= '0;
    end
    if ((state == S_SCAN) && pipe_v && take_best) begin
      best_idx   <= pipe_idx;
      best_stamp <= rd_stamp;
    end
    if (scan_hit) begin
      f        <= pipe_idx;
      is_hit   <= 1'b1;
      is_evict <= 1'b0;
      is_wb    <= 1'b0;
      victim   <= '0;
    end else if (scan_end) begin
      is_hit   <= 1'b0;
      is_evict <= 1'b0;
      is_wb    <= 1'b0;
      victim   <= '0;
      if (fill < n_lat)                  f <= HW'(fill);
      else if (pipe_v && take_best)      f <= pipe_idx;
      else                               f <= best_idx;
    end
    if ((state == S_MODW) && mod_done) begin
      f         <= HW'(mod_rem);
      clk_start <= HW'(mod_rem);
      iss_idx   <= HW'(mod_rem);
      iss_cnt   <= '0;
      scan_lim  <= n_lat;
    end
    if ((state == S_CLOCK) && (state_next == S_VREAD)) f <= choice;
    if (state == S_VWRITE) begin
      is_evict <= 1'b1;
      is_wb    <= rd_dirty;
      victim   <= rd_page;
    end
    if ((state == S_POST) && out_free) begin
      hit             <= is_hit;
      evicted         <= is_evict;
      writeback       <= is_wb;
      victim_page     <= victim;
      frame_index     <= pre_pkg::IDX_OUT_W'(f);
      hit_total       <= hit_count + CW'(is_hit);
      miss_total      <= miss_count + CW'(!is_hit);
      writeback_total <= wb_count + CW'(is_wb);
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state register not one-hot");
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && pipe_v) |-> (NW'(pipe_idx) < n_lat))
    else $error("scan read past the frame count");
  a_victim_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_VWRITE) |-> (NW'(f) < n_lat)) else $error("victim frame out of range");
  a_mod_wait: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MODW)) else $error("remainder result with nobody waiting");
  a_post_load: assert property (@(posedge clk) disable iff (rst)
    ((state == S_POST) && out_free) |=> (result_valid && (state == S_IDLE)))
    else $error("finished transaction not presented");

endmodule

// ===== src/pre_modu.sv =====
// Bit-serial remainder unit: dividend modulo a small divisor, one bit per cycle.
module pre_modu #(
  parameter int NW = pre_pkg::FC_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pre_pkg::LFSR_W-1:0] dividend,
  input  logic [NW-1:0]             divisor,
  output logic                      done,
  output logic [NW-1:0]             remainder
);

  localparam int CW = $clog2(pre_pkg::LFSR_W + 1);

  logic [CW-1:0]              cnt;
  logic [pre_pkg::LFSR_W-1:0] dvd;
  logic [NW:0]                trial;
  logic                       ge;

  assign trial = {remainder, dvd[pre_pkg::LFSR_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(pre_pkg::LFSR_W);
      end else if (cnt != '0) begin
        cnt  <= cnt - CW'(1);
        done <= (cnt == CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      remainder <= '0;
    end else if (cnt != '0) begin
      dvd       <= dvd << 1;
      remainder <= ge ? NW'(trial - {1'b0, divisor}) : NW'(trial);
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> cnt == '0) else $error("remainder unit restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("remainder done held over two cycles");
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (remainder < divisor)) else $error("remainder not below divisor");

endmodule
